// ===== hdl/tlge_pkg.sv =====
// Shared types, constants and helper functions for the toroidal life engine.
package tlge_pkg;

  // Default largest side, as a base-two logarithm
  localparam int MAX_LOG_SIDE_DEF = 6;

  // Fixed field and register widths
  localparam int COORD_W     = 6;
  localparam int LOG_REG_W   = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CNT_W       = 4;

  // Register reset value and register indexes
  localparam logic [LOG_REG_W-1:0]   LOG_RESET      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_HEIGHT = 1'b1;

  // Rule B3/S23
  localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;

  // Neighbor offsets, two-bit two's complement
  localparam logic [1:0] OFS_MINUS = 2'b11;
  localparam logic [1:0] OFS_ZERO  = 2'b00;
  localparam logic [1:0] OFS_PLUS  = 2'b01;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COUNT,
    ST_COUNT_END,
    ST_APPLY,
    ST_APPLY_END,
    ST_DONE
  } seq_state_t;

  // Accepted transaction handed to the sequencer
  typedef struct packed {
    logic start;
    op_t  op;
    logic write_bit;
  } cmd_t;

  // Finished result offered by the sequencer
  typedef struct packed {
    logic valid;
    logic read_bit;
    op_t  op;
  } res_t;

  // Column offset of neighbor k: upper row, own row, lower row, left to right
  function automatic logic [1:0] nbr_dx(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = OFS_MINUS;
      3'd1, 3'd6:       d = OFS_ZERO;
      default:          d = OFS_PLUS;
    endcase
    return d;
  endfunction

  // Row offset of neighbor k
  function automatic logic [1:0] nbr_dy(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = OFS_MINUS;
      3'd3, 3'd4:       d = OFS_ZERO;
      default:          d = OFS_PLUS;
    endcase
    return d;
  endfunction

  // Next state of one cell
  function automatic logic next_cell(input logic alive, input logic [CNT_W-1:0] n);
    return (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
  endfunction

endpackage

// ===== hdl/toroidal_life_generation_engine_unit.sv =====
// Top level of the toroidal B3/S23 life engine: config, handshake, output register.
// An advance makes two passes through the single cell-store read port: eight neighbor reads
// for every cell, then one rule update for every cell.
// One transaction is in progress at a time; a finished result waits in the output register.
// Reset: synchronous; a clearing pass over all 2^(2*MAX_LOG_SIDE) cells (4096 by default)
// kills all cells, with in_stall high throughout; config registers return to 6.
module toroidal_life_generation_engine_unit #(
  parameter int MAX_LOG_SIDE = tlge_pkg::MAX_LOG_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tlge_pkg::COORD_W-1:0]     col,
  input  logic [tlge_pkg::COORD_W-1:0]     row,
  input  logic [1:0]                       op,
  input  logic                             write_bit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             read_bit,
  output logic [1:0]                       done_op,
  input  logic                             cfg_we,
  input  logic [tlge_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlge_pkg::LOG_REG_W-1:0]   cfg_data
);
  import tlge_pkg::*;

  localparam int LOG_W = $clog2(MAX_LOG_SIDE + 1);
  localparam int XW    = (MAX_LOG_SIDE > COORD_W) ? MAX_LOG_SIDE : COORD_W;

  logic [LOG_REG_W-1:0]    log_width, log_height;
  logic [LOG_W-1:0]        lw, lh;
  logic [MAX_LOG_SIDE-1:0] wm, hm;
  logic [XW-1:0]           col_x, row_x;
  logic [MAX_LOG_SIDE-1:0] col_m, row_m;

  cmd_t cmd;
  res_t res;
  logic seq_ready, res_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      log_width  <= LOG_RESET;
      log_height <= LOG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOG_WIDTH:  log_width  <= cfg_data;
        REG_LOG_HEIGHT: log_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective grid size, clamped to 1..MAX_LOG_SIDE
  assign lw = (log_width == '0) ? LOG_W'(1) :
              (int'(log_width) > MAX_LOG_SIDE) ? LOG_W'(MAX_LOG_SIDE) : LOG_W'(log_width);
  assign lh = (log_height == '0) ? LOG_W'(1) :
              (int'(log_height) > MAX_LOG_SIDE) ? LOG_W'(MAX_LOG_SIDE) : LOG_W'(log_height);

  // Coordinate masks
  always_comb begin
    for (int j = 0; j < MAX_LOG_SIDE; j++) begin
      wm[j] = (j < int'(lw));
      hm[j] = (j < int'(lh));
    end
  end

  assign col_x = XW'(col);
  assign row_x = XW'(row);
  assign col_m = col_x[MAX_LOG_SIDE-1:0] & wm;
  assign row_m = row_x[MAX_LOG_SIDE-1:0] & hm;

  // Input transaction
  assign in_stall      = !seq_ready;
  assign cmd.start     = in_valid && !in_stall;
  assign cmd.op        = op_t'(op);
  assign cmd.write_bit = write_bit;

  tlge_seq #(
    .MAX_LOG_SIDE (MAX_LOG_SIDE)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .col      (col_m),
    .row      (row_m),
    .wm       (wm),
    .hm       (hm),
    .lw       (lw),
    .res_take (res_take),
    .ready    (seq_ready),
    .res      (res)
  );

  // Output register
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      read_bit <= res.read_bit;
      done_op  <= res.op;
    end
  end

endmodule

// ===== hdl/tlge_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module tlge_ram #(
  parameter int WIDTH  = 1,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tlge_seq.sv =====
// Sequencer: clearing pass, cell read/write, and the two-pass generation sweep.
module tlge_seq #(
  parameter int MAX_LOG_SIDE = tlge_pkg::MAX_LOG_SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tlge_pkg::cmd_t                       cmd,
  input  logic [MAX_LOG_SIDE-1:0]              col,
  input  logic [MAX_LOG_SIDE-1:0]              row,
  input  logic [MAX_LOG_SIDE-1:0]              wm,
  input  logic [MAX_LOG_SIDE-1:0]              hm,
  input  logic [$clog2(MAX_LOG_SIDE+1)-1:0]    lw,
  input  logic                                 res_take,
  output logic                                 ready,
  output tlge_pkg::res_t                       res
);
  import tlge_pkg::*;

  localparam int ADDR_W = 2 * MAX_LOG_SIDE;

  seq_state_t state, state_next;

  logic [ADDR_W-1:0]       clr_idx, clr_idx_next;
  logic [MAX_LOG_SIDE-1:0] c_cnt, c_cnt_next, r_cnt, r_cnt_next;
  logic [2:0]              k_cnt, k_cnt_next;
  logic [ADDR_W-1:0]       a_idx, a_idx_next;
  logic                    rb, rb_next;
  op_t                     op_reg, op_reg_next;

  // Count pipeline tag (valid in the cycle after the read issue)
  logic              d_valid, d_first, d_last;
  logic [ADDR_W-1:0] d_idx;
  logic [CNT_W-1:0]  acc, sum;

  // Apply pipeline tag
  logic              p_valid;
  logic [ADDR_W-1:0] p_idx;

  logic count_issue, apply_issue;

  // Memory ports
  logic              cell_we, cell_wdata, cell_rdata;
  logic [ADDR_W-1:0] cell_waddr, cell_raddr;
  logic [CNT_W-1:0]  cnt_rdata;

  // Shared address unit
  logic [1:0]              dx, dy;
  logic [MAX_LOG_SIDE-1:0] dcx, dry, n_col, n_row;
  logic [ADDR_W-1:0]       nbr_addr, own_addr, cmd_addr, last_addr;

  assign dx    = nbr_dx(k_cnt);
  assign dy    = nbr_dy(k_cnt);
  assign dcx   = MAX_LOG_SIDE'($signed(dx));
  assign dry   = MAX_LOG_SIDE'($signed(dy));
  assign n_col = (c_cnt + dcx) & wm;
  assign n_row = (r_cnt + dry) & hm;

  assign nbr_addr  = ADDR_W'(n_col) | (ADDR_W'(n_row) << lw);
  assign own_addr  = ADDR_W'(c_cnt) | (ADDR_W'(r_cnt) << lw);
  assign cmd_addr  = ADDR_W'(col)   | (ADDR_W'(row)   << lw);
  assign last_addr = ADDR_W'(wm)    | (ADDR_W'(hm)    << lw);

  // Neighbor accumulator: restarts on the first of eight bits
  assign sum = (d_first ? '0 : acc) + CNT_W'(cell_rdata);

  // Next state and memory control
  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    c_cnt_next   = c_cnt;
    r_cnt_next   = r_cnt;
    k_cnt_next   = k_cnt;
    a_idx_next   = a_idx;
    rb_next      = rb;
    op_reg_next  = op_reg;
    cell_we      = 1'b0;
    cell_waddr   = cmd_addr;
    cell_wdata   = cmd.write_bit;
    cell_raddr   = cmd_addr;
    count_issue  = 1'b0;
    apply_issue  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cell_we      = 1'b1;
        cell_waddr   = clr_idx;
        cell_wdata   = 1'b0;
        clr_idx_next = clr_idx + 1'b1;
        if (&clr_idx) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.start) begin
          rb_next     = 1'b0;
          op_reg_next = cmd.op;
          case (cmd.op)
            OP_WRITE: begin
              cell_we    = 1'b1;
              state_next = ST_DONE;
            end
            OP_READ: begin
              state_next = ST_READ;
            end
            OP_ADVANCE: begin
              c_cnt_next = '0;
              r_cnt_next = '0;
              k_cnt_next = '0;
              state_next = ST_COUNT;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        rb_next    = cell_rdata;
        state_next = ST_DONE;
      end
      ST_COUNT: begin
        cell_raddr  = nbr_addr;
        count_issue = 1'b1;
        k_cnt_next  = k_cnt + 1'b1;
        if (&k_cnt) begin
          c_cnt_next = (c_cnt + 1'b1) & wm;
          if (c_cnt == wm) begin
            r_cnt_next = (r_cnt + 1'b1) & hm;
            if (r_cnt == hm) begin
              state_next = ST_COUNT_END;
            end
          end
        end
      end
      ST_COUNT_END: begin
        // last count is written this cycle
        a_idx_next = '0;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cell_raddr  = a_idx;
        apply_issue = 1'b1;
        a_idx_next  = a_idx + 1'b1;
        if (a_idx == last_addr) begin
          state_next = ST_APPLY_END;
        end
      end
      ST_APPLY_END: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Rule write-back, in the cycle after the apply read
    if (p_valid) begin
      cell_we    = 1'b1;
      cell_waddr = p_idx;
      cell_wdata = next_cell(cell_rdata, cnt_rdata);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      d_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      d_valid <= count_issue;
      p_valid <= apply_issue;
    end
  end

  // Counters and pipeline payload
  always_ff @(posedge clk) begin
    c_cnt   <= c_cnt_next;
    r_cnt   <= r_cnt_next;
    k_cnt   <= k_cnt_next;
    a_idx   <= a_idx_next;
    rb      <= rb_next;
    op_reg  <= op_reg_next;
    d_first <= (k_cnt == '0);
    d_last  <= &k_cnt;
    d_idx   <= own_addr;
    p_idx   <= a_idx;
    if (d_valid) begin
      acc <= sum;
    end
  end

  tlge_ram #(
    .WIDTH  (1),
    .ADDR_W (ADDR_W)
  ) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  tlge_ram #(
    .WIDTH  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_counts (
    .clk   (clk),
    .we    (d_valid && d_last),
    .waddr (d_idx),
    .wdata (sum),
    .raddr (a_idx),
    .rdata (cnt_rdata)
  );

  assign ready        = (state == ST_IDLE);
  assign res.valid    = (state == ST_DONE);
  assign res.read_bit = rb;
  assign res.op       = op_reg;

endmodule
